// ----- rtl/core/mwm_pkg.sv -----
// ---------------------------------------------------------------------------
// mwm_pkg - shared types and constants for the mecanum wheel mixer
// Field widths, divider work item layout and the restoring divide step.
// ---------------------------------------------------------------------------
package mwm_pkg;

  localparam int IN_W      = 15;              // chassis command width
  localparam int LIM_W     = 15;              // wheel limit register width
  localparam int SUM_W     = IN_W + 2;        // three-term signed sum
  localparam int MAG_W     = SUM_W - 1;       // magnitude of a sum
  localparam int OUT_W     = 16;              // wheel speed result width
  localparam int PROD_W    = MAG_W + LIM_W;   // magnitude times limit
  localparam int QUO_W     = LIM_W;           // quotient never exceeds limit
  localparam int REM_W     = PROD_W - QUO_W;  // partial remainder width
  localparam int LANES     = 4;               // one lane per wheel
  localparam int DIV_STEPS = QUO_W;           // one quotient bit per stage

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(3500);

  typedef logic signed [IN_W-1:0]  cmd_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [OUT_W-1:0] wheel_t;
  typedef logic [LIM_W-1:0]        limit_t;

  // Work carried through the divider stages, all four wheels side by side
  typedef struct packed {
    logic [LANES-1:0][REM_W-1:0] rem;     // partial remainder
    logic [LANES-1:0][QUO_W-1:0] low;     // dividend bits still to shift in
    logic [LANES-1:0][QUO_W-1:0] quo;     // quotient bits so far
    logic [REM_W-1:0]            divisor; // peak wheel magnitude
    logic [LANES-1:0][OUT_W-1:0] raw;     // unscaled wheel speed
    logic [LANES-1:0]            neg;     // wheel speed is negative
    logic                        scale;   // peak exceeds the limit
  } div_work_t;

  // One restoring division step on every lane
  function automatic div_work_t div_step(input div_work_t cur);
    div_work_t        nxt;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   dvs;
    logic             ge;
    nxt = cur;
    dvs = {1'b0, cur.divisor};
    for (int i = 0; i < LANES; i++) begin
      trial = {cur.rem[i], cur.low[i][QUO_W-1]};
      ge    = (trial >= dvs);
      if (ge) begin
        nxt.rem[i] = REM_W'(trial - dvs);
      end else begin
        nxt.rem[i] = REM_W'(trial);
      end
      nxt.low[i] = {cur.low[i][QUO_W-2:0], 1'b0};
      nxt.quo[i] = {cur.quo[i][QUO_W-2:0], ge};
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/core/mwm_channels.sv -----
// ---------------------------------------------------------------------------
// mwm_channels - valid/ready channels of the mecanum wheel mixer
// Chassis command channel and wheel result channel.
// ---------------------------------------------------------------------------
interface mwm_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwm_pkg::IN_W-1:0]     speed_x;
  logic signed [mwm_pkg::IN_W-1:0]     speed_y;
  logic signed [mwm_pkg::IN_W-1:0]     spin_rate;

  modport source (output valid, output speed_x, output speed_y, output spin_rate,
                  input ready);
  modport sink (input valid, input speed_x, input speed_y, input spin_rate,
                output ready);
endinterface

interface mwm_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwm_pkg::OUT_W-1:0]    wheel0_speed;
  logic signed [mwm_pkg::OUT_W-1:0]    wheel1_speed;
  logic signed [mwm_pkg::OUT_W-1:0]    wheel2_speed;
  logic signed [mwm_pkg::OUT_W-1:0]    wheel3_speed;
  logic                                was_scaled;

  modport source (output valid, output wheel0_speed, output wheel1_speed,
                  output wheel2_speed, output wheel3_speed, output was_scaled,
                  input ready);
  modport sink (input valid, input wheel0_speed, input wheel1_speed,
                input wheel2_speed, input wheel3_speed, input was_scaled,
                output ready);
endinterface

// ----- rtl/core/mwm_divider.sv -----
// ---------------------------------------------------------------------------
// mwm_divider - pipelined four-lane restoring divider
// One quotient bit per stage for all wheels; each stage stalls on its own
// so bubbles collapse and nothing is lost or repeated.
// ---------------------------------------------------------------------------
module mwm_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mwm_pkg::div_work_t in_work,
  output logic               out_valid,
  input  logic               out_ready,
  output mwm_pkg::div_work_t out_work
);
  import mwm_pkg::*;

  logic [DIV_STEPS-1:0] valid;
  div_work_t            work [DIV_STEPS];
  logic [DIV_STEPS:0]   stage_rdy;
  logic [DIV_STEPS-1:0] src_valid;
  div_work_t            src_work [DIV_STEPS];

  // Ready chain: a stage takes new work when empty or when it moves on
  always_comb begin
    stage_rdy[DIV_STEPS] = out_ready;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid[k] || stage_rdy[k+1];
    end
  end

  // Feed each stage from the one before it
  always_comb begin
    src_valid[0] = in_valid;
    src_work[0]  = in_work;
    for (int k = 1; k < DIV_STEPS; k++) begin
      src_valid[k] = valid[k-1];
      src_work[k]  = work[k-1];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (stage_rdy[k]) begin
          valid[k] <= src_valid[k];
        end
      end
    end
  end

  // Advance stage work, one quotient bit per stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (stage_rdy[k]) begin
        work[k] <= div_step(src_work[k]);
      end
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = valid[DIV_STEPS-1];
  assign out_work  = work[DIV_STEPS-1];

`ifndef ASSERT_OFF
  // Scaled lanes keep the partial remainder below the divisor
  a_rem_first: assert property (@(posedge clk) disable iff (rst)
    valid[0] && work[0].scale |-> work[0].rem[0] < work[0].divisor)
    else $error("divider remainder not below divisor in first stage");

  a_rem_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_work.scale |-> out_work.rem[LANES-1] < out_work.divisor)
    else $error("divider remainder not below divisor in last stage");

  // A stalled result stays in the last stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("divider dropped a stalled result");
`endif

endmodule

// ----- rtl/core/mecanum_wheel_mixer.sv -----
// ---------------------------------------------------------------------------
// mecanum_wheel_mixer - mecanum chassis inverse kinematics
// Mixes a chassis command into four wheel speeds and scales all wheels by
// limit / peak when the largest magnitude exceeds the wheel limit.
//
//   channel  direction  handshake      contents
//   cmd      in         valid/ready    speed_x, speed_y, spin_rate
//   res      out        valid/ready    wheel0..3_speed, was_scaled
//   cfg      in         cfg_we         cfg_wdata = max_wheel_speed
//
// One transaction per cycle unless res.ready stalls; stages: mix, magnitude and peak,
// multiply by the limit, 15 divider stages (one quotient bit each), output.
// Reset clears every valid bit and loads the limit with 3500.
// Each stage stalls independently, so bubbles collapse under back pressure.
// ---------------------------------------------------------------------------
module mecanum_wheel_mixer (
  input  logic                      clk,
  input  logic                      rst,
  mwm_cmd_if.sink                   cmd,
  mwm_res_if.source                 res,
  input  logic                      cfg_we,
  input  logic [mwm_pkg::LIM_W-1:0] cfg_wdata
);
  import mwm_pkg::*;

  limit_t                  limit;
  logic                    s1_valid, s2_valid, s3_valid;
  logic                    s1_ready, s2_ready, s3_ready;
  sum_t   [LANES-1:0]      s1_sum;
  mag_t   [LANES-1:0]      s2_mag;
  logic   [LANES-1:0]      s2_neg;
  logic   [LANES-1:0][OUT_W-1:0] s2_raw;
  mag_t                    s2_peak;
  div_work_t               s3_work;
  sum_t                    x_ext, y_ext, s_ext;
  sum_t   [LANES-1:0]      sum_next;
  mag_t   [LANES-1:0]      mag_next;
  mag_t                    peak_a, peak_b, peak_next;
  div_work_t               work_next;
  logic [PROD_W-1:0]       prod;
  logic                    div_in_ready, div_out_valid, div_out_ready;
  div_work_t               div_out;
  logic                    out_valid;
  wheel_t [LANES-1:0]      out_wheel;
  logic                    out_scaled;
  wheel_t [LANES-1:0]      wheel_next;
  logic [OUT_W-1:0]        quo_ext;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // Ready chain
  assign s3_ready  = !s3_valid || div_in_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign cmd.ready = s1_ready;
  assign div_out_ready = !out_valid || res.ready;

  // Stage 1: mix the command into four wheel sums
  always_comb begin
    x_ext = SUM_W'(cmd.speed_x);
    y_ext = SUM_W'(cmd.speed_y);
    s_ext = SUM_W'(cmd.spin_rate);
    sum_next[0] =  x_ext - y_ext + s_ext;
    sum_next[1] =  x_ext + y_ext + s_ext;
    sum_next[2] = -x_ext + y_ext + s_ext;
    sum_next[3] = -x_ext - y_ext + s_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_sum <= sum_next;
    end
  end

  // Stage 2: magnitudes and peak
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag_next[i] = s1_sum[i][SUM_W-1] ? MAG_W'(-s1_sum[i]) : MAG_W'(s1_sum[i]);
    end
    peak_a    = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
    peak_b    = (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
    peak_next = (peak_a > peak_b) ? peak_a : peak_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_mag  <= mag_next;
      s2_peak <= peak_next;
      for (int i = 0; i < LANES; i++) begin
        s2_neg[i] <= s1_sum[i][SUM_W-1];
        s2_raw[i] <= s1_sum[i][OUT_W-1:0];
      end
    end
  end

  // Stage 3: magnitude times limit, load the divider work item
  always_comb begin
    work_next         = '0;
    work_next.divisor = REM_W'(s2_peak);
    work_next.raw     = s2_raw;
    work_next.neg     = s2_neg;
    work_next.scale   = ({1'b0, s2_peak} > (MAG_W + 1)'(limit));
    prod              = '0;
    for (int i = 0; i < LANES; i++) begin
      prod              = PROD_W'(s2_mag[i]) * PROD_W'(limit);
      work_next.rem[i]  = prod[PROD_W-1:QUO_W];
      work_next.low[i]  = prod[QUO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_work <= work_next;
    end
  end

  // Divide each wheel magnitude by the peak
  mwm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (div_in_ready),
    .in_work   (s3_work),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_work  (div_out)
  );

  // Output stage: restore signs or pass unscaled speeds
  always_comb begin
    quo_ext = '0;
    for (int i = 0; i < LANES; i++) begin
      quo_ext = OUT_W'(div_out.quo[i]);
      if (!div_out.scale) begin
        wheel_next[i] = div_out.raw[i];
      end else if (div_out.neg[i]) begin
        wheel_next[i] = -quo_ext;
      end else begin
        wheel_next[i] = quo_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_out_ready) begin
      out_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready) begin
      out_wheel  <= wheel_next;
      out_scaled <= div_out.scale;
    end
  end

  assign res.valid        = out_valid;
  assign res.wheel0_speed = out_wheel[0];
  assign res.wheel1_speed = out_wheel[1];
  assign res.wheel2_speed = out_wheel[2];
  assign res.wheel3_speed = out_wheel[3];
  assign res.was_scaled   = out_scaled;

`ifndef ASSERT_OFF
  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");

  // An empty mix stage always takes a command
  a_cmd_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> cmd.ready)
    else $error("command stalled while mix stage empty");

  // A new result comes only from the divider
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(div_out_valid))
    else $error("result appeared without divider output");
`endif

endmodule

// ----- tb/tb_mecanum_wheel_mixer.sv -----
// ---------------------------------------------------------------------------
// tb_mecanum_wheel_mixer - self-checking testbench for the wheel mixer
// Sends chassis commands through the command channel with random gaps and
// random back pressure, predicts the four wheel speeds and the scaling flag
// for each accepted command, and compares every result in order. The wheel
// limit is rewritten between phases, covering zero, one and the maximum.
// ---------------------------------------------------------------------------
module tb_mecanum_wheel_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import mwm_pkg::*;

  localparam int TIMEOUT_CYCLES = 100000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int IDLE_PCT       = 23;
  localparam int RANDOM_PER_SET = 200;

  typedef struct packed {
    wheel_t [LANES-1:0] speed;
    logic               scaled;
  } wheel_set_t;

  // Predict wheel speeds and check results in arrival order
  class wheel_speed_checker;
    limit_t     limit;
    wheel_set_t expected_wheels[$];
    int         mismatches;
    int         results_seen;
    int         scaled_seen;

    function new();
      limit        = LIMIT_RESET;
      mismatches   = 0;
      results_seen = 0;
      scaled_seen  = 0;
    endfunction

    function wheel_set_t mix_wheels(cmd_t x, cmd_t y, cmd_t s);
      wheel_set_t r;
      int         sum [LANES];
      longint     mag;
      longint     peak;
      longint     q;
      sum[0] = int'(x) - int'(y) + int'(s);
      sum[1] = int'(x) + int'(y) + int'(s);
      sum[2] = -int'(x) + int'(y) + int'(s);
      sum[3] = -int'(x) - int'(y) + int'(s);
      peak = 0;
      for (int i = 0; i < LANES; i++) begin
        mag = (sum[i] < 0) ? -longint'(sum[i]) : longint'(sum[i]);
        if (mag > peak) begin
          peak = mag;
        end
      end
      r.scaled = (peak > longint'(limit));
      for (int i = 0; i < LANES; i++) begin
        if (r.scaled) begin
          // truncate toward zero on the magnitude, then restore the sign
          mag = (sum[i] < 0) ? -longint'(sum[i]) : longint'(sum[i]);
          q   = (mag * longint'(limit)) / peak;
          r.speed[i] = wheel_t'((sum[i] < 0) ? -q : q);
        end else begin
          r.speed[i] = wheel_t'(sum[i]);
        end
      end
      return r;
    endfunction

    function void note_command(cmd_t x, cmd_t y, cmd_t s);
      expected_wheels.push_back(mix_wheels(x, y, s));
    endfunction

    function void check_result(wheel_set_t got);
      wheel_set_t exp_set;
      results_seen++;
      if (expected_wheels.size() == 0) begin
        $display("%0t: unexpected result, wheels %0d %0d %0d %0d scaled %0b", $realtime,
                 got.speed[0], got.speed[1], got.speed[2], got.speed[3], got.scaled);
        mismatches++;
        return;
      end
      exp_set = expected_wheels.pop_front();
      if (exp_set.scaled) begin
        scaled_seen++;
      end
      for (int i = 0; i < LANES; i++) begin
        if (got.speed[i] !== exp_set.speed[i]) begin
          $display("%0t: wheel%0d_speed expected %0d actual %0d", $realtime, i,
                   exp_set.speed[i], got.speed[i]);
          mismatches++;
        end
      end
      if (got.scaled !== exp_set.scaled) begin
        $display("%0t: was_scaled expected %0b actual %0b", $realtime,
                 exp_set.scaled, got.scaled);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   cfg_we;
  limit_t cfg_wdata;

  mwm_cmd_if cmd_ch ();
  mwm_res_if res_ch ();

  mecanum_wheel_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  wheel_speed_checker wheel_check = new();

  int cycles        = 0;
  int commands_sent = 0;
  int limit_sets    = 1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quiet window: no idling on either side while it is open
  function automatic bit take_gap();
    if (commands_sent >= 700 && commands_sent < 1000) begin
      return 1'b0;
    end
    return ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Result side back pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= !take_gap();
    end
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    wheel_set_t got;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        wheel_check.note_command(cmd_ch.speed_x, cmd_ch.speed_y, cmd_ch.spin_rate);
        commands_sent++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got.speed[0] = res_ch.wheel0_speed;
        got.speed[1] = res_ch.wheel1_speed;
        got.speed[2] = res_ch.wheel2_speed;
        got.speed[3] = res_ch.wheel3_speed;
        got.scaled   = res_ch.was_scaled;
        wheel_check.check_result(got);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("mecanum_wheel_mixer test failed");
      $finish;
    end
  end

  // Offer one command; return once it has been taken
  task automatic send_command(input cmd_t x, input cmd_t y, input cmd_t s);
    @(negedge clk);
    while (take_gap()) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.speed_x   <= x;
    cmd_ch.speed_y   <= y;
    cmd_ch.spin_rate <= s;
    @(posedge clk);
    while (!cmd_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and hold until every wheel set has come back
  task automatic drain_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (wheel_check.expected_wheels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Load a new wheel limit while the mixer is empty
  task automatic write_limit(input limit_t lim);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    wheel_check.limit = lim;
    limit_sets++;
  endtask

  // One random command, shaped around the current limit
  task automatic send_random(input limit_t lim);
    int   pick;
    int   peak;
    int   span;
    int   part;
    int   v [3];
    cmd_t c [3];
    pick = $urandom_range(99);
    v    = '{0, 0, 0};
    if (pick < 55) begin
      // inside the nominal command range
      for (int i = 0; i < 3; i++) begin
        v[i] = int'($urandom_range(20000)) - 10000;
      end
    end else if (pick < 70) begin
      // any 15-bit pattern
      for (int i = 0; i < 3; i++) begin
        v[i] = int'(cmd_t'($urandom));
      end
    end else if (pick < 85) begin
      // peak right at, just under or just over the limit
      peak = int'(lim) + int'($urandom_range(2)) - 1;
      if (peak < 0) begin
        peak = 0;
      end
      if (peak > 16383) begin
        peak = 16383;
      end
      if ($urandom_range(1)) begin
        v[$urandom_range(2)] = $urandom_range(1) ? peak : -peak;
      end else begin
        part = int'($urandom_range(peak));
        v[0] = $urandom_range(1) ? part : -part;
        v[1] = (v[0] < 0) ? -(peak - part) : (peak - part);
      end
    end else if (pick < 95) begin
      // moderate commands whose peak lands near the limit
      span = (int'(lim) >> 1) + 1;
      if (span > 16383) begin
        span = 16383;
      end
      for (int i = 0; i < 3; i++) begin
        v[i] = int'($urandom_range(2 * span)) - span;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        v[i] = int'($urandom_range(6)) - 3;
      end
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = cmd_t'(v[i]);
    end
    send_command(c[0], c[1], c[2]);
  endtask

  // Stimulus
  initial begin
    limit_t limit_plan [9];
    limit_plan = '{limit_t'(0), limit_t'(1), limit_t'(32767), limit_t'(16384),
                   limit_t'(2), limit_t'($urandom_range(32767, 1)),
                   limit_t'($urandom_range(200, 1)), limit_t'(3500),
                   limit_t'($urandom_range(32767, 1))};

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.speed_x   = '0;
    cmd_ch.speed_y   = '0;
    cmd_ch.spin_rate = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes and boundary cases at the reset limit
    send_command(0, 0, 0);
    send_command(16383, 16383, 16383);
    send_command(-16384, -16384, -16384);
    send_command(16383, -16384, 16383);
    send_command(-16384, 16383, -16384);
    send_command(-16384, -16384, 16383);
    send_command(10000, 10000, 10000);
    send_command(-10000, -10000, -10000);
    send_command(10000, -10000, 10000);
    send_command(10000, 0, 0);
    send_command(0, -10000, 0);
    send_command(0, 0, 10000);
    send_command(3500, 0, 0);
    send_command(0, 0, -3500);
    send_command(3501, 0, 0);
    send_command(1750, 1750, 0);
    send_command(1750, 1751, 0);
    send_command(1, -1, 1);
    send_command(-1, 0, 0);
    send_command(3499, 0, 1);
    for (int n = 0; n < RANDOM_PER_SET; n++) begin
      send_random(wheel_check.limit);
    end

    // Sweep the limit; each setting opens with zero and unit commands
    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      send_command(0, 0, 0);
      send_command(1, 0, 0);
      send_command(0, 0, -1);
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        send_random(wheel_check.limit);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d chassis commands across %0d wheel limit settings.", commands_sent,
             limit_sets);
    $display("Checked %0d wheel sets, %0d of them scaled down to the limit.",
             wheel_check.results_seen, wheel_check.scaled_seen);
    if (wheel_check.mismatches == 0 && wheel_check.expected_wheels.size() == 0) begin
      $display("mecanum_wheel_mixer test passed");
    end else begin
      $display("mecanum_wheel_mixer test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mwm_pkg.sv
rtl/core/mwm_channels.sv
rtl/core/mwm_divider.sv
rtl/core/mecanum_wheel_mixer.sv
tb/tb_mecanum_wheel_mixer.sv
